// File: src/stsi_pkg.sv
// shared types, codes and defaults for the sorted table block
package stsi_pkg;

    // default number of table entries
    localparam int CAPACITY_DEF = 64;

    // field widths fixed by the interface
    localparam int KEY_W   = 32;
    localparam int RANK_W  = 6;
    localparam int COUNT_W = 7;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;

    // number of ranks the rank field can address
    localparam int RANK_LIMIT = 1 << RANK_W;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FIND   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD_RANK  = 2'd3;

    // command broadcast to every cell
    typedef struct packed {
        logic                     do_insert;
        logic                     do_delete;
        logic signed [KEY_W-1:0]  key;
        logic [RANK_W-1:0]        rank;
    } cell_cmd_t;

    // compare flags one cell hands to its right neighbor and to the top level
    typedef struct packed {
        logic le;
        logic lt;
        logic hit;
    } cell_flags_t;

endpackage

// File: src/stsi_cell.sv
// one table cell: holds the entry at a fixed rank and shifts with its neighbors
module stsi_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                                 aclk,
    input  stsi_pkg::cell_cmd_t                  cmd_i,
    input  logic [CW-1:0]                        count_i,
    input  logic                                 left_le_i,
    input  logic signed [stsi_pkg::KEY_W-1:0]    left_value_i,
    input  logic signed [stsi_pkg::KEY_W-1:0]    right_value_i,
    output logic signed [stsi_pkg::KEY_W-1:0]    value_o,
    output stsi_pkg::cell_flags_t                flags_o,
    output logic [stsi_pkg::KEY_W-1:0]           read_o
);

    localparam logic [CW-1:0] IDX_W = IDX[CW-1:0];
    localparam bit READABLE = (IDX < stsi_pkg::RANK_LIMIT);
    localparam logic [stsi_pkg::RANK_W-1:0] IDX_R = IDX[stsi_pkg::RANK_W-1:0];

    logic signed [stsi_pkg::KEY_W-1:0] value_reg;
    logic signed [stsi_pkg::KEY_W-1:0] value_next;
    logic                              occupied;
    logic                              rank_hit;

    // compare against the broadcast key
    assign occupied   = (IDX_W < count_i);
    assign flags_o.le = occupied && (value_reg <= cmd_i.key);
    assign flags_o.lt = occupied && (value_reg < cmd_i.key);
    assign flags_o.hit = occupied && (value_reg == cmd_i.key);

    // read contribution, zero unless this cell holds the requested rank
    assign rank_hit = READABLE && occupied && (cmd_i.rank == IDX_R);
    assign read_o   = rank_hit ? value_reg : '0;

    // keep, take the key, or shift from a neighbor
    always_comb begin
        value_next = value_reg;
        if (cmd_i.do_insert) begin
            if (!flags_o.le) begin
                value_next = left_le_i ? cmd_i.key : left_value_i;
            end
        end else if (cmd_i.do_delete) begin
            if (!flags_o.lt) begin
                value_next = right_value_i;
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value_o = value_reg;

endmodule

// File: src/sorted_table_insert_delete_find.sv
// top level of the sorted table: cell row, entry count and result register
//
// Keeps up to CAPACITY signed 32-bit values in ascending order in a row of
// cells, one entry per cell. Requests arrive on the s_ stream channel and
// each gives exactly one result on the m_ stream channel.
//   insert: the new value goes after any equal values; dropped when full
//   delete: removes the lowest-ranked equal value, or reports not found
//   find:   reports whether the value is stored
//   read:   returns the entry at an ascending rank
// Every cell compares its entry with the key in the same cycle and takes
// its new value from itself, the key or a neighbor, so a request is done
// in the cycle it is accepted. The result appears in the output register
// in the cycle after acceptance; one request per cycle is sustained while m_tready stays high.
// The output register frees up in the cycle it is taken, so s_tready is
// high whenever the result slot is empty or m_tready is high. When the
// receiver stalls, s_tready drops and the held result stays stable.
// Reset (aresetn low, synchronous) empties the table at once and drops
// any pending result; cell contents are not cleared.
module sorted_table_insert_delete_find #(
    parameter int CAPACITY = stsi_pkg::CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input: key_value[31:0], rank_index[37:32], zero fill [39:38]
    input  logic [39:0] s_tdata,
    // input: req_type[1:0]
    input  logic [1:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // result: read_value[31:0], entry_count[38:32], zero fill [39]
    output logic [39:0] m_tdata,
    // result: status[1:0], found[2]
    output logic [2:0]  m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_W = CAPACITY[CW-1:0];

    logic                                req;
    logic signed [stsi_pkg::KEY_W-1:0]   key;
    logic [stsi_pkg::RANK_W-1:0]         rank;
    logic                                accept;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic                           m_valid_reg;
    logic                           m_valid_next;
    logic [stsi_pkg::STAT_W-1:0]    status_reg;
    logic [stsi_pkg::STAT_W-1:0]    status_next;
    logic                           found_reg;
    logic                           found_next;
    logic [stsi_pkg::KEY_W-1:0]     rdval_reg;
    logic [stsi_pkg::KEY_W-1:0]     rdval_next;
    logic [stsi_pkg::COUNT_W-1:0]   ecount_reg;
    logic [stsi_pkg::COUNT_W-1:0]   ecount_next;
    logic [CW+stsi_pkg::COUNT_W-1:0] count_ext;

    stsi_pkg::cell_cmd_t  cmd;
    logic                 is_full;
    logic                 any_hit;
    logic [stsi_pkg::KEY_W-1:0] read_any;

    logic signed [stsi_pkg::KEY_W-1:0] cell_value [CAPACITY];
    stsi_pkg::cell_flags_t             cell_flags [CAPACITY];
    logic [stsi_pkg::KEY_W-1:0]        cell_read  [CAPACITY];

    logic [stsi_pkg::REQ_W-1:0] req_type;

    // unpack the input transaction
    assign req_type = s_tuser;
    assign key      = s_tdata[31:0];
    assign rank     = s_tdata[37:32];
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign req      = accept;

    assign is_full = (count_reg == CAP_W);

    // command for the cell row
    always_comb begin
        cmd.key       = key;
        cmd.rank      = rank;
        cmd.do_insert = req && (req_type == stsi_pkg::REQ_INSERT) && !is_full;
        cmd.do_delete = req && (req_type == stsi_pkg::REQ_DELETE) && any_hit;
    end

    // row of cells
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                              left_le;
        logic signed [stsi_pkg::KEY_W-1:0] left_value;
        logic signed [stsi_pkg::KEY_W-1:0] right_value;

        if (i == 0) begin : g_first
            assign left_le    = 1'b1;
            assign left_value = key;
        end else begin : g_inner
            assign left_le    = cell_flags[i-1].le;
            assign left_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_value = cell_value[i];
        end else begin : g_mid
            assign right_value = cell_value[i+1];
        end

        stsi_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .aclk          (aclk),
            .cmd_i         (cmd),
            .count_i       (count_reg),
            .left_le_i     (left_le),
            .left_value_i  (left_value),
            .right_value_i (right_value),
            .value_o       (cell_value[i]),
            .flags_o       (cell_flags[i]),
            .read_o        (cell_read[i])
        );
    end

    // gather match and read results over the row
    always_comb begin
        any_hit  = 1'b0;
        read_any = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            any_hit  = any_hit | cell_flags[i].hit;
            read_any = read_any | cell_read[i];
        end
    end

    // entry count
    always_comb begin
        count_next = count_reg;
        if (cmd.do_insert) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.do_delete) begin
            count_next = count_reg - 1'b1;
        end
    end

    assign count_ext = {{stsi_pkg::COUNT_W{1'b0}}, count_next};

    // result for the accepted transaction
    always_comb begin
        status_next = status_reg;
        found_next  = found_reg;
        rdval_next  = rdval_reg;
        ecount_next = ecount_reg;
        if (accept) begin
            status_next = stsi_pkg::STAT_OK;
            found_next  = 1'b0;
            rdval_next  = '0;
            ecount_next = count_ext[stsi_pkg::COUNT_W-1:0];
            case (req_type)
                stsi_pkg::REQ_INSERT: begin
                    if (is_full) begin
                        status_next = stsi_pkg::STAT_FULL;
                    end
                end
                stsi_pkg::REQ_DELETE, stsi_pkg::REQ_FIND: begin
                    found_next = any_hit;
                    if (!any_hit) begin
                        status_next = stsi_pkg::STAT_NOT_FOUND;
                    end
                end
                stsi_pkg::REQ_READ: begin
                    rdval_next = read_any;
                    if ({{CW{1'b0}}, rank} >= {{stsi_pkg::RANK_W{1'b0}}, count_reg}) begin
                        status_next = stsi_pkg::STAT_BAD_RANK;
                    end
                end
                default: begin
                    status_next = stsi_pkg::STAT_OK;
                end
            endcase
        end
    end

    // output slot handshake
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload registers
    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        found_reg  <= found_next;
        rdval_reg  <= rdval_next;
        ecount_reg <= ecount_next;
    end

    // pack the result transaction
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, ecount_reg, rdval_reg};
    assign m_tuser  = {found_reg, status_reg};

endmodule
